>>> hw/rtl/kti_pkg.sv
// shared types and constants for the keyframe track interpolator
// no dependencies
`default_nettype none
package kti_pkg;
  localparam int MaxKeys = 64;
  localparam int AddrW = $clog2(MaxKeys);
  localparam int CntW = $clog2(MaxKeys + 1);
  localparam logic [21:0] DegPerRadQ16 = 22'd3754936;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;

  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_BEFORE = 3'd1;
  localparam logic [2:0] ST_AFTER = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_LOADED = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;
  localparam logic [2:0] ST_ORDER = 3'd6;

  localparam logic [1:0] REG_DEGREES = 2'd0;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  // start pulse and operands for the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hw/rtl/keyframe_track_interpolator.sv
// keyframe track interpolator: key table in one synchronous memory, linear scan
// query, sequenced interpolation and degrees scaling; uses kti_pkg and kti_div
// load/clear: read last key, then clear, reject (full table or out-of-order key) or store
// query: scan keys, interpolate each axis with kti_div, then degrees scaling if enabled;
// the next beat is taken in the same cycle the result appears
// synchronous reset empties the table and clears degrees mode; memory is not cleared
`default_nettype none
module keyframe_track_interpolator import kti_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] key_time,
  input  wire logic [31:0] key_x,
  input  wire logic [31:0] key_y,
  input  wire logic [31:0] key_z,
  input  wire logic [31:0] query_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [2:0]       status
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LAST  = 10'b0000000010,
    S_LOAD  = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_EVAL  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WAIT  = 10'b0001000000,
    S_DEG   = 10'b0010000000,
    S_DEG2  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  key_t mem [MaxKeys];
  key_t rd;
  logic [AddrW-1:0] raddr;
  logic [CntW-1:0] count;
  logic degrees;
  logic [1:0] op_r;
  key_t in_r;
  logic [31:0] q_r;
  logic [AddrW-1:0] idx;
  key_t prev;
  logic [31:0] num, den;
  logic [1:0] comp;
  logic signed [33:0] res [3];
  logic signed [33:0] diff;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [55:0] dprod;
  div_req_t dreq;
  div_rsp_t drsp;
  logic div_start;
  logic [31:0] div_divisor;
  logic [2:0] st_r;

  assign pready = 1'b1;
  assign prdata = {31'd0, degrees};
  always_ff @(posedge clk) begin
    if (rst) degrees <= 1'b0;
    else if (psel && penable && pwrite && paddr == REG_DEGREES) degrees <= pwdata[0];
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (state == S_LOAD && op_r == OP_LOAD && st_r == ST_LOADED)
      mem[count[AddrW-1:0]] <= in_r;
  end

  assign dreq = '{start: div_start, dividend: prod + 64'(den >> 1), divisor: div_divisor};

  kti_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready = (state == S_IDLE);

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fffffff;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  always_comb begin
    unique case (comp)
      2'd0: diff = $signed({{2{rd.x[31]}}, rd.x}) - $signed({{2{prev.x[31]}}, prev.x});
      2'd1: diff = $signed({{2{rd.y[31]}}, rd.y}) - $signed({{2{prev.y[31]}}, prev.y});
      default: diff = $signed({{2{rd.z[31]}}, rd.z}) - $signed({{2{prev.z[31]}}, prev.z});
    endcase
    mag = diff[33] ? 32'(-diff) : diff[31:0];
  end

  logic [31:0] a_comp;
  always_comb begin
    unique case (comp)
      2'd0: a_comp = prev.x;
      2'd1: a_comp = prev.y;
      default: a_comp = prev.z;
    endcase
  end

  logic signed [33:0] dv;
  logic [33:0] dmag;
  logic [39:0] dsh;
  assign dv = res[comp];
  assign dmag = dv[33] ? 34'(-dv) : dv;
  assign dsh = 40'((dprod + 56'h8000) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      comp <= '0;
    end else begin
      div_start <= (state == S_DIV);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op_r <= op;
          in_r <= '{t: key_time, x: key_x, y: key_y, z: key_z};
          q_r <= query_time;
          res[0] <= '0; res[1] <= '0; res[2] <= '0;
          idx <= '0;
          if (op == OP_LOAD || op == OP_CLEAR) begin
            raddr <= AddrW'(count - CntW'(1));
            state <= S_LAST;
          end
          else if (count == '0) begin st_r <= ST_EMPTY; state <= S_OUT; end
          else begin raddr <= '0; state <= S_SCAN; end
        end
        S_LAST: state <= S_LOAD;  // memory read of last key in flight
        S_LOAD: begin
          if (op_r == OP_CLEAR) begin
            count <= '0; st_r <= ST_LOADED; state <= S_OUT;
          end else if (count == CntW'(MaxKeys)) begin
            st_r <= ST_FULL; state <= S_OUT;
          end else if (count != '0 && in_r.t < rd.t) begin
            st_r <= ST_ORDER; state <= S_OUT;
          end else if (st_r != ST_LOADED) begin
            st_r <= ST_LOADED;  // write happens next cycle
          end else begin
            count <= count + CntW'(1); state <= S_OUT;
          end
        end
        S_SCAN: state <= S_EVAL;
        S_EVAL: begin
          if (rd.t >= q_r) begin
            if (idx == '0) begin
              res[0] <= $signed({{2{rd.x[31]}}, rd.x});
              res[1] <= $signed({{2{rd.y[31]}}, rd.y});
              res[2] <= $signed({{2{rd.z[31]}}, rd.z});
              st_r <= ST_BEFORE; comp <= 2'd0; state <= S_DEG;
            end else begin
              num <= q_r - prev.t; den <= rd.t - prev.t;
              st_r <= ST_INTERP; comp <= 2'd0; state <= S_DIV;
            end
          end else if ({1'b0, idx} == count - CntW'(1)) begin
            res[0] <= $signed({{2{rd.x[31]}}, rd.x});
            res[1] <= $signed({{2{rd.y[31]}}, rd.y});
            res[2] <= $signed({{2{rd.z[31]}}, rd.z});
            st_r <= ST_AFTER; comp <= 2'd0; state <= S_DEG;
          end else begin
            prev <= rd;
            idx <= idx + AddrW'(1);
            raddr <= idx + AddrW'(1);
            state <= S_SCAN;
          end
        end
        S_DIV: begin
          prod <= 64'(mag) * 64'(num);
          div_divisor <= den;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (drsp.done) begin
            res[comp] <= diff[33]
              ? $signed({{2{a_comp[31]}}, a_comp}) - $signed({1'b0, drsp.quot[32:0]})
              : $signed({{2{a_comp[31]}}, a_comp}) + $signed({1'b0, drsp.quot[32:0]});
            if (comp == 2'd2) begin comp <= 2'd0; state <= S_DEG; end
            else begin comp <= comp + 2'd1; state <= S_DIV; end
          end
        end
        S_DEG: begin
          if (!degrees) state <= S_OUT;
          else begin dprod <= 56'(dmag) * 56'(DegPerRadQ16); state <= S_DEG2; end
        end
        S_DEG2: begin
          if (dv[33]) res[comp] <= (dsh > 40'h80000000) ? -34'sd2147483648
                                    : -$signed({1'b0, dsh[32:0]});
          else res[comp] <= (dsh > 40'h7fffffff) ? 34'sd2147483647
                            : $signed({1'b0, dsh[32:0]});
          if (comp == 2'd2) state <= S_OUT;
          else begin comp <= comp + 2'd1; state <= S_DEG; end
        end
        S_OUT: if (!out_valid) begin
          out_x <= sat32(res[0]); out_y <= sat32(res[1]); out_z <= sat32(res[2]);
          status <= st_r; out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && in_valid && in_ready && op == OP_LOAD) st_r <= ST_INTERP;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/kti_div.sv
// restoring unsigned divider, one quotient bit per cycle, 64 by 32 bits
// depends on kti_pkg
`default_nettype none
module kti_div import kti_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [63:0] q;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem, q[63]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 7'd63);
      if (req.start) begin
        busy <= 1'b1;
        q <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) busy <= 1'b0;
      end
    end
  end
  assign rsp = '{done: done, quot: q};
endmodule
`default_nettype wire

>>> hw/rtl/kti_checker.sv
// port-level checks for the keyframe track interpolator
// depends on kti_pkg; bound to keyframe_track_interpolator
`default_nettype none
module kti_checker import kti_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] status,
  input wire logic [31:0] out_x
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 3'd7) else $error("bad status");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second beat taken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status)) else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_LOADED || status == ST_EMPTY)) |-> out_x == 32'd0)
    else $error("nonzero vector");
endmodule
bind keyframe_track_interpolator kti_checker u_chk (.*);
`default_nettype wire
